@@ hdl/egg_drop_min_trials_defines.svh @@
// assertion macros for the egg drop block
`ifndef EGG_DROP_MIN_TRIALS_DEFINES_SVH
`define EGG_DROP_MIN_TRIALS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EDMT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edmt check failed");

// next-cycle implication, disabled during reset
`define EDMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edmt check failed");

`endif

@@ hdl/edmt_pkg.sv @@
`default_nettype none

package edmt_pkg;

	localparam int VAL_W = 9;
	localparam int EGG_W = 5;

	localparam logic [VAL_W-1:0] ALL_ONES = '1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INIT  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_STORE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

@@ hdl/egg_drop_min_trials.sv @@
// trivial queries (too many floors, zero eggs, one egg, <= 1 floor) go straight to done without the table
// otherwise init fills the one-egg row, then scan and store fill a row for each egg count from 2 to E
// each drop floor takes one read of each table row, which feeds one max/add/compare unit
// one query in flight; a new word is taken while the previous answer waits at the output
// async active-low reset clears the sequencer and output valid; table rows are not cleared
`default_nettype none

`include "egg_drop_min_trials_defines.svh"

module egg_drop_min_trials #(
	parameter int MAX_FLOORS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [8:0] floors,
	input  wire logic [4:0] eggs,
	input  wire logic       query_valid,
	output logic            query_ready,
	output logic [8:0]      min_trials,
	output logic            valid_res,
	output logic            answer_valid,
	input  wire logic       answer_ready
);

	import edmt_pkg::*;

	localparam int DEPTH = ((MAX_FLOORS < 511) ? MAX_FLOORS : 511) + 1;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [31:0] FLOOR_LIMIT = 32'(MAX_FLOORS);

	state_t           state_q;
	logic [VAL_W-1:0] nf_q;
	logic [EGG_W-1:0] ne_q;
	logic [EGG_W-1:0] egg_q;
	logic [VAL_W-1:0] floor_q;
	logic [VAL_W-1:0] drop_q;
	logic [VAL_W-1:0] best_q;
	logic             sel_q;
	logic             scan_s1;
	logic [VAL_W-1:0] res_trials_q;
	logic             res_ok_q;
	logic [VAL_W-1:0] ans_trials_q;
	logic             ans_ok_q;
	logic             ans_valid_q;

	logic [VAL_W-1:0] mem0 [DEPTH];
	logic [VAL_W-1:0] mem1 [DEPTH];
	logic [VAL_W-1:0] m0_rd_s1;
	logic [VAL_W-1:0] m1_rd_s1;

	logic [VAL_W-1:0] prev_idx;
	logic [VAL_W-1:0] cur_idx;
	logic [AW-1:0]    m0_ra;
	logic [AW-1:0]    m1_ra;
	logic [AW-1:0]    wa;
	logic [VAL_W-1:0] wd;
	logic             m0_we;
	logic             m1_we;
	logic [VAL_W-1:0] prev_rd;
	logic [VAL_W-1:0] cur_rd;
	logic [VAL_W-1:0] worst;
	logic [VAL_W-1:0] cand;
	logic             too_many;
	logic             out_free;

	// read addresses for the broken and unbroken cases
	assign prev_idx = drop_q - VAL_W'(1);
	assign cur_idx  = floor_q - drop_q;
	assign m0_ra    = sel_q ? cur_idx[AW-1:0] : prev_idx[AW-1:0];
	assign m1_ra    = sel_q ? prev_idx[AW-1:0] : cur_idx[AW-1:0];

	assign prev_rd = sel_q ? m1_rd_s1 : m0_rd_s1;
	assign cur_rd  = sel_q ? m0_rd_s1 : m1_rd_s1;
	assign worst   = ((prev_rd > cur_rd) ? prev_rd : cur_rd) + VAL_W'(1);
	assign cand    = (scan_s1 && (worst < best_q)) ? worst : best_q;

	// init fills both rows with the one-egg row; store writes the current row
	assign wa    = floor_q[AW-1:0];
	assign wd    = (state_q == ST_STORE) ? cand : floor_q;
	assign m0_we = (state_q == ST_INIT) || ((state_q == ST_STORE) && sel_q);
	assign m1_we = (state_q == ST_INIT) || ((state_q == ST_STORE) && !sel_q);

	assign too_many = {23'd0, floors} > FLOOR_LIMIT;
	assign out_free = !ans_valid_q || answer_ready;

	always_ff @(posedge clk) begin
		if (m0_we) begin
			mem0[wa] <= wd;
		end
		m0_rd_s1 <= mem0[m0_ra];
	end

	always_ff @(posedge clk) begin
		if (m1_we) begin
			mem1[wa] <= wd;
		end
		m1_rd_s1 <= mem1[m1_ra];
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			ans_trials_q <= res_trials_q;
			ans_ok_q     <= res_ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nf_q         <= '0;
			ne_q         <= '0;
			egg_q        <= '0;
			floor_q      <= '0;
			drop_q       <= '0;
			best_q       <= ALL_ONES;
			sel_q        <= 1'b0;
			scan_s1      <= 1'b0;
			res_trials_q <= '0;
			res_ok_q     <= 1'b0;
			ans_valid_q  <= 1'b0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_DONE) && out_free) begin
				ans_valid_q <= 1'b1;
			end else if (ans_valid_q && answer_ready) begin
				ans_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_valid) begin
						nf_q <= floors;
						ne_q <= eggs;
						if (too_many) begin
							res_trials_q <= '0;
							res_ok_q     <= 1'b0;
							state_q      <= ST_DONE;
						end else if (eggs == '0) begin
							res_trials_q <= '0;
							res_ok_q     <= (floors == '0);
							state_q      <= ST_DONE;
						end else if ((eggs == EGG_W'(1)) || (floors <= VAL_W'(1))) begin
							res_trials_q <= floors;
							res_ok_q     <= 1'b1;
							state_q      <= ST_DONE;
						end else begin
							floor_q <= '0;
							sel_q   <= 1'b0;
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					if (floor_q == nf_q) begin
						floor_q <= VAL_W'(2);
						drop_q  <= VAL_W'(1);
						egg_q   <= EGG_W'(2);
						best_q  <= ALL_ONES;
						state_q <= ST_SCAN;
					end else begin
						floor_q <= floor_q + VAL_W'(1);
					end
				end
				ST_SCAN: begin
					best_q <= cand;
					if (drop_q == floor_q) begin
						state_q <= ST_STORE;
					end else begin
						drop_q <= drop_q + VAL_W'(1);
					end
				end
				ST_STORE: begin
					best_q <= ALL_ONES;
					drop_q <= VAL_W'(1);
					if (floor_q == nf_q) begin
						if (egg_q == ne_q) begin
							res_trials_q <= cand;
							res_ok_q     <= 1'b1;
							state_q      <= ST_DONE;
						end else begin
							egg_q   <= egg_q + EGG_W'(1);
							sel_q   <= ~sel_q;
							floor_q <= VAL_W'(2);
							state_q <= ST_SCAN;
						end
					end else begin
						floor_q <= floor_q + VAL_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign query_ready  = (state_q == ST_IDLE);
	assign answer_valid = ans_valid_q;
	assign min_trials   = ans_trials_q;
	assign valid_res    = ans_ok_q;

	// drop floor stays within the floor being filled
	`EDMT_ASSERT_NOW(a_drop_range, state_q == ST_SCAN, (drop_q != '0) && (drop_q <= floor_q))
	// a store either starts the next floor or finishes the query
	`EDMT_ASSERT_NEXT(a_store_next, state_q == ST_STORE, (state_q == ST_SCAN) || (state_q == ST_DONE))
	// a rejected query always reports zero drops
	`EDMT_ASSERT_NOW(a_invalid_zero, answer_valid && !valid_res, min_trials == '0)

endmodule

`default_nettype wire
